@@ rtl/sbo_pkg.sv @@
// Shared types and constants for the segment boundary overlay.
// Holds register codes, field widths and the result record.
// No dependencies.
package sbo_pkg;

    localparam int FRAME_WIDTH_BITS  = 12;
    localparam int FRAME_HEIGHT_BITS = 13;
    localparam int ROW_BITS          = 12;
    localparam int CHAN_BITS         = 8;
    localparam int IN_LABEL_BITS     = 16;
    localparam int APB_ADDR_BITS     = 3;
    localparam int APB_DATA_BITS     = 32;

    localparam logic [FRAME_WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;
    localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_MIN   = 13'd3;
    localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_MAX   = 13'd4096;

    localparam logic [CHAN_BITS-1:0] PAINT_CHAN0 = 8'd0;
    localparam logic [CHAN_BITS-1:0] PAINT_CHAN1 = 8'd0;
    localparam logic [CHAN_BITS-1:0] PAINT_CHAN2 = 8'd255;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } sbo_reg_t;

    typedef struct packed {
        logic [FRAME_WIDTH_BITS-1:0]  frame_width;
        logic [FRAME_HEIGHT_BITS-1:0] frame_height;
        logic                         restart;
    } sbo_cfg_t;

    typedef struct packed {
        logic [CHAN_BITS-1:0] out_chan0;
        logic [CHAN_BITS-1:0] out_chan1;
        logic [CHAN_BITS-1:0] out_chan2;
        logic [CHAN_BITS-1:0] out_chan3;
        logic                 is_boundary;
        logic                 last_of_run;
        logic                 end_of_frame;
    } sbo_result_t;

endpackage

@@ rtl/sbo_if.sv @@
// Stream interfaces for the segment boundary overlay: pixel input and result output.
// Each carries valid, ready and the payload fields. Depends on sbo_pkg.
interface sbo_pix_if
    import sbo_pkg::*;
    ;
    logic                     valid;
    logic                     ready;
    logic [CHAN_BITS-1:0]     in_chan0;
    logic [CHAN_BITS-1:0]     in_chan1;
    logic [CHAN_BITS-1:0]     in_chan2;
    logic [CHAN_BITS-1:0]     in_chan3;
    logic [IN_LABEL_BITS-1:0] seg_label;

    modport source (output valid, in_chan0, in_chan1, in_chan2, in_chan3, seg_label,
                    input ready);
    modport sink (input valid, in_chan0, in_chan1, in_chan2, in_chan3, seg_label,
                  output ready);
endinterface

interface sbo_res_if
    import sbo_pkg::*;
    ;
    logic                 valid;
    logic                 ready;
    logic [CHAN_BITS-1:0] out_chan0;
    logic [CHAN_BITS-1:0] out_chan1;
    logic [CHAN_BITS-1:0] out_chan2;
    logic [CHAN_BITS-1:0] out_chan3;
    logic                 is_boundary;
    logic                 last_of_run;
    logic                 end_of_frame;

    modport source (output valid, out_chan0, out_chan1, out_chan2, out_chan3,
                    is_boundary, last_of_run, end_of_frame,
                    input ready);
    modport sink (input valid, out_chan0, out_chan1, out_chan2, out_chan3,
                  is_boundary, last_of_run, end_of_frame,
                  output ready);
endinterface

@@ rtl/segment_boundary_overlay.sv @@
// Top level of the segment boundary overlay: counters, boundary test and wiring.
// Uses sbo_pkg, sbo_if, sbo_cfg_regs, sbo_line_store and sbo_result_fifo.
//
//   channel   direction  handshake          payload
//   pix_in    in         valid/ready        in_chan0..3, seg_label
//   res_out   out        valid/ready        out_chan0..3, is_boundary, last_of_run,
//                                           end_of_frame
//   apb       in         psel/penable/...   frame_width @0x0, frame_height @0x4
//
// One pixel per cycle on every row but the last, while the result queue has room; the last
// row yields two results per pixel, and the single result port drains them one at a time
// and so holds input back. A result is registered into the queue when its pixel is taken.
// After reset and after every register write, pix_in.ready stays low while the line
// stores prefetch column zero; counters restart at row 0, column 0.
// A four-entry result queue absorbs stalls; pix_in.ready drops when fewer than two
// entries are free.
module segment_boundary_overlay
    import sbo_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int LABEL_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    sbo_pix_if.sink                  pix_in,
    sbo_res_if.source                res_out,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > FRAME_WIDTH_BITS) ? CW + 1 : FRAME_WIDTH_BITS;

    sbo_cfg_t               cfg;
    logic [WW-1:0]          fw_ext;
    logic [WW-1:0]          w_eff;
    logic [CW-1:0]          col_last;
    logic [CW-1:0]          col_pen;
    logic [FRAME_HEIGHT_BITS-1:0] h_eff;
    logic [ROW_BITS-1:0]    row_last;

    logic [CW-1:0]          col_reg, col_next;
    logic [ROW_BITS-1:0]    row_reg, row_next;
    logic [LABEL_BITS-1:0]  left_label_reg, left_label_next;
    logic                   prefetch_ok_reg;

    logic                   fifo_room;
    logic                   accept;
    logic [LABEL_BITS-1:0]  cur_label;
    logic [4*CHAN_BITS-1:0] cur_pixel;
    logic [LABEL_BITS-1:0]  up_label, right_label, up2_label;
    logic [4*CHAN_BITS-1:0] up_pixel;
    logic [CW-1:0]          rd_addr;
    logic                   last_row, last_col, interior, boundary;
    logic                   push0, push1;
    sbo_result_t            res_above, res_own;

    sbo_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Saturate the frame size registers to the supported range.
    always_comb
    begin
        fw_ext = WW'(cfg.frame_width);
        if (fw_ext < WW'(3))
        begin
            w_eff = WW'(3);
        end
        else if (fw_ext > WW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = fw_ext;
        end

        if (cfg.frame_height < FRAME_HEIGHT_MIN)
        begin
            h_eff = FRAME_HEIGHT_MIN;
        end
        else if (cfg.frame_height > FRAME_HEIGHT_MAX)
        begin
            h_eff = FRAME_HEIGHT_MAX;
        end
        else
        begin
            h_eff = cfg.frame_height;
        end
    end

    assign col_last = CW'(w_eff - WW'(1));
    assign col_pen  = CW'(w_eff - WW'(2));
    assign row_last = ROW_BITS'(h_eff - FRAME_HEIGHT_BITS'(1));

    assign pix_in.ready = prefetch_ok_reg && fifo_room;
    assign accept       = pix_in.valid && pix_in.ready;

    assign cur_label = LABEL_BITS'(pix_in.seg_label);
    assign cur_pixel = {pix_in.in_chan3, pix_in.in_chan2, pix_in.in_chan1, pix_in.in_chan0};

    assign last_row = row_reg == row_last;
    assign last_col = col_reg == col_last;
    assign interior = (row_reg >= ROW_BITS'(2)) && (col_reg >= CW'(1)) && (col_reg <= col_pen);
    assign boundary = interior && ((up_label != right_label) || (up_label != up2_label) ||
                                   (up_label != left_label_reg) || (up_label != cur_label));

    always_comb
    begin
        col_next        = col_reg;
        row_next        = row_reg;
        left_label_next = left_label_reg;
        if (cfg.restart)
        begin
            col_next        = '0;
            row_next        = '0;
            left_label_next = '0;
        end
        else if (accept)
        begin
            left_label_next = up_label;
            if (last_col)
            begin
                col_next        = '0;
                left_label_next = '0;
                row_next        = last_row ? '0 : row_reg + ROW_BITS'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    // Read ahead at the column the next pixel will use.
    assign rd_addr = accept ? col_next : col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            row_reg         <= '0;
            left_label_reg  <= '0;
            prefetch_ok_reg <= 1'b0;
        end
        else
        begin
            col_reg         <= col_next;
            row_reg         <= row_next;
            left_label_reg  <= left_label_next;
            prefetch_ok_reg <= !cfg.restart;
        end
    end

    sbo_line_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .LABEL_BITS (LABEL_BITS),
        .CW         (CW)
    ) u_line_store (
        .clk         (clk),
        .wr_en       (accept),
        .wr_addr     (col_reg),
        .wr_label    (cur_label),
        .wr_label_up (up_label),
        .wr_pixel    (cur_pixel),
        .rd_addr     (rd_addr),
        .up_label    (up_label),
        .right_label (right_label),
        .up2_label   (up2_label),
        .up_pixel    (up_pixel)
    );

    always_comb
    begin
        res_above.out_chan0    = boundary ? PAINT_CHAN0 : up_pixel[7:0];
        res_above.out_chan1    = boundary ? PAINT_CHAN1 : up_pixel[15:8];
        res_above.out_chan2    = boundary ? PAINT_CHAN2 : up_pixel[23:16];
        res_above.out_chan3    = up_pixel[31:24];
        res_above.is_boundary  = boundary;
        res_above.last_of_run  = !last_row;
        res_above.end_of_frame = 1'b0;

        res_own.out_chan0    = pix_in.in_chan0;
        res_own.out_chan1    = pix_in.in_chan1;
        res_own.out_chan2    = pix_in.in_chan2;
        res_own.out_chan3    = pix_in.in_chan3;
        res_own.is_boundary  = 1'b0;
        res_own.last_of_run  = 1'b1;
        res_own.end_of_frame = last_col;
    end

    // Drop results on the first row; add the pixel's own result on the last row.
    assign push0 = accept && (row_reg != '0);
    assign push1 = push0 && last_row;

    sbo_result_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push0    (push0),
        .push1    (push1),
        .data0    (res_above),
        .data1    (res_own),
        .has_room (fifo_room),
        .res      (res_out)
    );

endmodule

@@ rtl/sbo_cfg_regs.sv @@
// APB register block for the segment boundary overlay: frame width and height.
// Flags a restart on every completed write. Depends on sbo_pkg.
module sbo_cfg_regs
    import sbo_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output sbo_cfg_t                 cfg
);

    logic [FRAME_WIDTH_BITS-1:0]  frame_width_reg;
    logic [FRAME_HEIGHT_BITS-1:0] frame_height_reg;
    logic                         wr_en;
    sbo_reg_t                     reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = sbo_reg_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[FRAME_WIDTH_BITS-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[FRAME_HEIGHT_BITS-1:0];
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_FRAME_WIDTH:  prdata = APB_DATA_BITS'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_BITS'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.frame_width  = frame_width_reg;
    assign cfg.frame_height = frame_height_reg;
    assign cfg.restart      = wr_en;

endmodule

@@ rtl/sbo_line_store.sv @@
// Line stores for the previous two label rows and the previous pixel row.
// Read data is registered; the previous-label store has two read ports. Depends on sbo_pkg.
module sbo_line_store
    import sbo_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int LABEL_BITS = 16,
    parameter int CW         = $clog2(MAX_WIDTH)
)
(
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [CW-1:0]          wr_addr,
    input  logic [LABEL_BITS-1:0]  wr_label,
    input  logic [LABEL_BITS-1:0]  wr_label_up,
    input  logic [4*CHAN_BITS-1:0] wr_pixel,
    input  logic [CW-1:0]          rd_addr,
    output logic [LABEL_BITS-1:0]  up_label,
    output logic [LABEL_BITS-1:0]  right_label,
    output logic [LABEL_BITS-1:0]  up2_label,
    output logic [4*CHAN_BITS-1:0] up_pixel
);

    logic [LABEL_BITS-1:0]  label_prev_mem  [MAX_WIDTH];
    logic [LABEL_BITS-1:0]  label_prev2_mem [MAX_WIDTH];
    logic [4*CHAN_BITS-1:0] pixel_prev_mem  [MAX_WIDTH];
    logic [CW-1:0]          rd_addr_right;

    assign rd_addr_right = rd_addr + CW'(1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            label_prev_mem[wr_addr]  <= wr_label;
            label_prev2_mem[wr_addr] <= wr_label_up;
            pixel_prev_mem[wr_addr]  <= wr_pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        up_label    <= label_prev_mem[rd_addr];
        right_label <= label_prev_mem[rd_addr_right];
        up2_label   <= label_prev2_mem[rd_addr];
        up_pixel    <= pixel_prev_mem[rd_addr];
    end

endmodule

@@ rtl/sbo_result_fifo.sv @@
// Four-entry result queue that takes up to two results per cycle and releases one.
// Drives the result stream interface. Depends on sbo_pkg and sbo_if.
module sbo_result_fifo
    import sbo_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push0,
    input  logic         push1,
    input  sbo_result_t  data0,
    input  sbo_result_t  data1,
    output logic         has_room,
    sbo_res_if.source    res
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    sbo_result_t    entry_reg [DEPTH];
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW:0]    count_reg, count_next;
    logic           pop;
    logic [1:0]     push_cnt;
    sbo_result_t    head;

    assign pop      = res.valid && res.ready;
    assign push_cnt = {1'b0, push0} + {1'b0, push1};
    assign has_room = count_reg <= (PW + 1)'(DEPTH - 2);

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        wr_ptr_next = wr_ptr_reg + PW'(push_cnt);
        count_next  = count_reg + (PW + 1)'(push_cnt) - (PW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            entry_reg[wr_ptr_reg] <= data0;
        end
        if (push1)
        begin
            entry_reg[wr_ptr_reg + PW'(1)] <= data1;
        end
    end

    assign head             = entry_reg[rd_ptr_reg];
    assign res.valid        = count_reg != '0;
    assign res.out_chan0    = head.out_chan0;
    assign res.out_chan1    = head.out_chan1;
    assign res.out_chan2    = head.out_chan2;
    assign res.out_chan3    = head.out_chan3;
    assign res.is_boundary  = head.is_boundary;
    assign res.last_of_run  = head.last_of_run;
    assign res.end_of_frame = head.end_of_frame;

endmodule
